### src/lpet_pkg.sv
`timescale 1ns / 1ps

package lpet_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Item field widths.
  localparam int HANDLE_W = 32;
  localparam int PRIO_W   = 16;
  localparam int FILL_W   = 9;
  localparam int FILL_MAX = (1 << FILL_W) - 1;

  // Stream data widths, padded to whole bytes.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_RELINK,
    ST_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit_append;
    logic scan_read;
    logic scan_first;
    logic new_evict;
    logic unlink;
    logic relink;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic new_lowest;
    logic out_free;
  } dp_status_t;

endpackage

### src/lowest_priority_eviction_table.sv
`timescale 1ns / 1ps
// Channel  Ports            Contents
// in       in_t*  (48 b)    entry_handle, priority_req
// out      out_t* (64 b)    evicted, evicted_is_new, evicted_handle, evicted_priority,
//                           fill_count
//
// Entries are kept in a linked list in arrival order inside block memories.
// While the table is filling, an item is appended to the list; once full, an item is
// handled by the one-read-per-cycle walk of the list that finds the oldest lowest.
// Reset is synchronous, active low, and empties the table; no clearing pass.
// A stalled result sits in the output register while the next item is accepted.

module lowest_priority_eviction_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // entry_handle [31:0], priority_req [47:32]
  input  logic [lpet_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // evicted [0], evicted_is_new [1], evicted_handle [33:2],
  // evicted_priority [49:34], fill_count [58:50], zeros [63:59]
  output logic [lpet_pkg::OUT_DATA_W-1:0]   out_tdata
);

  lpet_pkg::dp_cmd_t                cmd;
  lpet_pkg::dp_status_t             status;
  logic                             evicted;
  logic                             evicted_is_new;
  logic [lpet_pkg::HANDLE_W-1:0]    evicted_handle;
  logic [lpet_pkg::PRIO_W-1:0]      evicted_priority;
  logic [lpet_pkg::FILL_W-1:0]      fill_count;

  // Sequencer.
  lpet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Storage, scan and result registers.
  lpet_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_handle   (in_tdata[31:0]),
    .in_prio     (in_tdata[47:32]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_evicted (evicted),
    .out_is_new  (evicted_is_new),
    .out_handle  (evicted_handle),
    .out_prio    (evicted_priority),
    .out_fill    (fill_count)
  );

  // Pack the result item.
  assign out_tdata = {5'b0, fill_count, evicted_priority, evicted_handle,
                      evicted_is_new, evicted};

endmodule

### src/lpet_ctrl.sv
`timescale 1ns / 1ps

module lpet_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  lpet_pkg::dp_status_t status,
  output lpet_pkg::dp_cmd_t    cmd
);

  lpet_pkg::state_t                 state_r;
  lpet_pkg::state_t                 state_nxt;
  logic [lpet_pkg::IDX_W-1:0]       scan_cnt_r;
  logic [lpet_pkg::IDX_W-1:0]       scan_cnt_nxt;
  logic                             scan_last;

  assign scan_last = (scan_cnt_r == lpet_pkg::IDX_W'(lpet_pkg::TABLE_DEPTH - 1));

  // State and scan counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lpet_pkg::ST_IDLE;
      scan_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    unique case (state_r)
      lpet_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          scan_cnt_nxt = '0;
          state_nxt    = status.full ? lpet_pkg::ST_SCAN : lpet_pkg::ST_APPEND;
        end
      end
      lpet_pkg::ST_APPEND: begin
        state_nxt = lpet_pkg::ST_RESULT;
      end
      lpet_pkg::ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_last) begin
          state_nxt = lpet_pkg::ST_DRAIN;
        end
      end
      lpet_pkg::ST_DRAIN: begin
        state_nxt = lpet_pkg::ST_DECIDE;
      end
      lpet_pkg::ST_DECIDE: begin
        state_nxt = status.new_lowest ? lpet_pkg::ST_RESULT : lpet_pkg::ST_RELINK;
      end
      lpet_pkg::ST_RELINK: begin
        state_nxt = lpet_pkg::ST_RESULT;
      end
      lpet_pkg::ST_RESULT: begin
        if (status.out_free) begin
          state_nxt = lpet_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lpet_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      lpet_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      lpet_pkg::ST_APPEND: begin
        cmd.commit_append = 1'b1;
      end
      lpet_pkg::ST_SCAN: begin
        cmd.scan_read  = 1'b1;
        cmd.scan_first = (scan_cnt_r == '0);
      end
      lpet_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      lpet_pkg::ST_DECIDE: begin
        cmd.new_evict = status.new_lowest;
        cmd.unlink    = !status.new_lowest;
      end
      lpet_pkg::ST_RELINK: begin
        cmd.relink = 1'b1;
      end
      lpet_pkg::ST_RESULT: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### src/lpet_datapath.sv
`timescale 1ns / 1ps

module lpet_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lpet_pkg::dp_cmd_t                cmd,
  output lpet_pkg::dp_status_t             status,
  input  logic [lpet_pkg::HANDLE_W-1:0]    in_handle,
  input  logic [lpet_pkg::PRIO_W-1:0]      in_prio,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_evicted,
  output logic                             out_is_new,
  output logic [lpet_pkg::HANDLE_W-1:0]    out_handle,
  output logic [lpet_pkg::PRIO_W-1:0]      out_prio,
  output logic [lpet_pkg::FILL_W-1:0]      out_fill
);

  localparam int IW = lpet_pkg::IDX_W;
  localparam int CW = lpet_pkg::CNT_W;
  localparam int HW = lpet_pkg::HANDLE_W;
  localparam int PW = lpet_pkg::PRIO_W;
  localparam int FW = lpet_pkg::FILL_W;

  // Entry storage plus an arrival-order link for each slot.
  logic [HW-1:0] handle_mem [lpet_pkg::TABLE_DEPTH];
  logic [PW-1:0] prio_mem   [lpet_pkg::TABLE_DEPTH];
  logic [IW-1:0] link_mem   [lpet_pkg::TABLE_DEPTH];

  logic [HW-1:0] new_handle_r;
  logic [PW-1:0] new_prio_r;
  logic [CW-1:0] count_r;
  logic [IW-1:0] head_r;
  logic [IW-1:0] tail_r;

  // Registered read port.
  logic [HW-1:0] rd_handle_r;
  logic [PW-1:0] rd_prio_r;
  logic [IW-1:0] rd_link_r;
  logic [IW-1:0] rd_addr_r;
  logic          rd_valid_r;
  logic          rd_first_r;
  logic [IW-1:0] rd_addr;

  // Running minimum of the scan.
  logic [IW-1:0] prev_addr_r;
  logic [HW-1:0] min_handle_r;
  logic [PW-1:0] min_prio_r;
  logic [IW-1:0] low_r;
  logic [IW-1:0] low_prev_r;
  logic [IW-1:0] low_link_r;
  logic          low_is_head_r;
  logic          low_is_tail;

  // Result waiting for the output register.
  logic          res_evicted_r;
  logic          res_is_new_r;
  logic [HW-1:0] res_handle_r;
  logic [PW-1:0] res_prio_r;
  logic [FW-1:0] res_fill_r;
  logic [FW-1:0] fill_now;

  logic          out_valid_r;
  logic          out_evicted_r;
  logic          out_is_new_r;
  logic [HW-1:0] out_handle_r;
  logic [PW-1:0] out_prio_r;
  logic [FW-1:0] out_fill_r;

  // Write port controls.
  logic          data_we;
  logic [IW-1:0] data_waddr;
  logic          link_we;
  logic [IW-1:0] link_waddr;
  logic [IW-1:0] link_wdata;
  logic [IW-1:0] append_slot;

  assign append_slot = count_r[IW-1:0];
  assign low_is_tail = (low_r == tail_r);
  assign rd_addr     = cmd.scan_first ? head_r : rd_link_r;

  // Fill count saturates at the field's maximum for very deep tables.
  always_comb begin
    if (32'(count_r) > 32'(lpet_pkg::FILL_MAX)) begin
      fill_now = FW'(lpet_pkg::FILL_MAX);
    end else begin
      fill_now = FW'(count_r);
    end
  end

  // Select writes for an append, an unlink or a relink.
  always_comb begin
    data_we    = cmd.commit_append | cmd.unlink;
    data_waddr = cmd.unlink ? low_r : append_slot;
    link_we    = 1'b0;
    link_waddr = tail_r;
    link_wdata = append_slot;
    if (cmd.commit_append) begin
      link_we = (count_r != '0);
    end else if (cmd.unlink) begin
      link_we    = !low_is_tail && !low_is_head_r;
      link_waddr = low_prev_r;
      link_wdata = low_link_r;
    end else if (cmd.relink) begin
      link_we    = !low_is_tail;
      link_wdata = low_r;
    end
  end

  // Memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (data_we) begin
      handle_mem[data_waddr] <= new_handle_r;
      prio_mem[data_waddr]   <= new_prio_r;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    rd_handle_r <= handle_mem[rd_addr];
    rd_prio_r   <= prio_mem[rd_addr];
    rd_link_r   <= link_mem[rd_addr];
    rd_addr_r   <= rd_addr;
    rd_first_r  <= cmd.scan_first;
  end

  // Read valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.scan_read;
    end
  end

  // Scan: a strict compare keeps the oldest of equal priorities.
  always_ff @(posedge clk) begin
    if (rd_valid_r) begin
      prev_addr_r <= rd_addr_r;
      if (rd_first_r || (rd_prio_r < min_prio_r)) begin
        min_handle_r  <= rd_handle_r;
        min_prio_r    <= rd_prio_r;
        low_r         <= rd_addr_r;
        low_prev_r    <= prev_addr_r;
        low_link_r    <= rd_link_r;
        low_is_head_r <= rd_first_r;
      end
    end
  end

  // Offered item capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      new_handle_r <= in_handle;
      new_prio_r   <= in_prio;
    end
  end

  // List pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
    end else if (cmd.commit_append) begin
      count_r <= count_r + 1'b1;
      tail_r  <= append_slot;
      if (count_r == '0) begin
        head_r <= append_slot;
      end
    end else if (cmd.unlink) begin
      if (!low_is_tail && low_is_head_r) begin
        head_r <= low_link_r;
      end
    end else if (cmd.relink) begin
      tail_r <= low_r;
    end
  end

  // Result of the current item.
  always_ff @(posedge clk) begin
    if (cmd.commit_append) begin
      res_evicted_r <= 1'b0;
      res_is_new_r  <= 1'b0;
      res_handle_r  <= '0;
      res_prio_r    <= '0;
      res_fill_r    <= FW'(32'(count_r) + 32'd1 > 32'(lpet_pkg::FILL_MAX)
                          ? lpet_pkg::FILL_MAX : 32'(count_r) + 32'd1);
    end else if (cmd.new_evict) begin
      res_evicted_r <= 1'b1;
      res_is_new_r  <= 1'b1;
      res_handle_r  <= new_handle_r;
      res_prio_r    <= new_prio_r;
      res_fill_r    <= fill_now;
    end else if (cmd.unlink) begin
      res_evicted_r <= 1'b1;
      res_is_new_r  <= 1'b0;
      res_handle_r  <= min_handle_r;
      res_prio_r    <= min_prio_r;
      res_fill_r    <= fill_now;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_evicted_r <= res_evicted_r;
      out_is_new_r  <= res_is_new_r;
      out_handle_r  <= res_handle_r;
      out_prio_r    <= res_prio_r;
      out_fill_r    <= res_fill_r;
    end
  end

  assign status.full       = (count_r == CW'(lpet_pkg::TABLE_DEPTH));
  assign status.new_lowest = (new_prio_r < min_prio_r);
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_evicted = out_evicted_r;
  assign out_is_new  = out_is_new_r;
  assign out_handle  = out_handle_r;
  assign out_prio    = out_prio_r;
  assign out_fill    = out_fill_r;

endmodule
